>>> rtl/core/btmx_pkg.sv
// Shared constants, types and helpers for the binary trie max-xor block.
// No dependencies; used by btmx_cell and binary_trie_max_xor_top.
`default_nettype none

package btmx_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int NODE_COUNT_DEF = 4096;

	localparam int STATUS_W = 2;
	localparam int NEED_W   = 7;   // missing-node count along one path, up to 127

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// walk token handed from one level cell to the next
	typedef struct packed {
		logic              valid;
		logic              stop;   // path ended above this level
		logic [NEED_W-1:0] need;   // nodes missing so far on an insert path
	} walk_ctl_t;

	// entries of the node RAM of the cell at depth d (entry 0 unused)
	function automatic int cell_depth(int d, int node_count);
		int idx_w;
		int cap;
		idx_w = $clog2(node_count);
		if (d >= idx_w) begin
			cap = node_count - 1;
		end else begin
			cap = 1 << d;
			if (cap > node_count - 1) begin
				cap = node_count - 1;
			end
		end
		return cap + 1;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/btmx_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module btmx_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/core/btmx_cell.sv
// One trie level: node RAM for its depth, walk step and path commit.
// Depends on btmx_pkg and btmx_ram.
`default_nettype none

module btmx_cell #(
	parameter int IDX_W = 12,
	parameter int DEPTH = 2
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cmd_i,
	input  wire logic                      bit_i,     // value bit of this level
	input  wire btmx_pkg::walk_ctl_t       ctl_i,
	input  wire logic [IDX_W-1:0]          idx_i,
	output btmx_pkg::walk_ctl_t            ctl_o,
	output logic      [IDX_W-1:0]          idx_o,
	output logic                           bit_o,     // result bit of a query
	input  wire logic                      commit_i,
	input  wire logic [IDX_W-1:0]          alloc_i,   // next free index one level down
	output logic      [IDX_W-1:0]          alloc_o
);

	localparam int AW = $clog2(DEPTH);
	localparam int LW = 2 * IDX_W;

	btmx_pkg::walk_ctl_t ctl_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    fill_q;
	logic                miss_q;
	logic                after_q;
	logic [IDX_W-1:0]    cur_q;
	logic [IDX_W-1:0]    other_q;
	logic                bit_q;

	logic [LW-1:0]    rdata;
	logic [LW-1:0]    wdata;
	logic             we;
	logic [IDX_W-1:0] widx;
	logic [IDX_W-1:0] keep;
	logic             node_ok;
	logic [IDX_W-1:0] link0;
	logic [IDX_W-1:0] link1;
	logic [IDX_W-1:0] same;
	logic [IDX_W-1:0] opp;
	logic             hit_miss;
	logic             take_opp;

	btmx_ram #(
		.WIDTH(LW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(widx[AW-1:0]),
		.wdata(wdata),
		.raddr(idx_i[AW-1:0]),
		.rdata(rdata)
	);

	// entries above the fill count were never written; root reads as empty
	assign node_ok = ctl_q.valid && !ctl_q.stop && (idx_q != '0) && (idx_q <= fill_q);
	assign link0   = node_ok ? rdata[IDX_W-1:0]  : '0;
	assign link1   = node_ok ? rdata[LW-1:IDX_W] : '0;
	assign same    = bit_i ? link1 : link0;
	assign opp     = bit_i ? link0 : link1;

	always_comb begin
		ctl_o.valid = ctl_q.valid;
		ctl_o.stop  = 1'b1;
		ctl_o.need  = ctl_q.need;
		idx_o       = '0;
		hit_miss    = 1'b0;
		take_opp    = 1'b0;
		if (cmd_i == btmx_pkg::CMD_INSERT) begin
			if (!ctl_q.stop && (same != '0)) begin
				ctl_o.stop = 1'b0;
				idx_o      = same;
			end else begin
				ctl_o.need = ctl_q.need + 1'b1;
				hit_miss   = !ctl_q.stop;
			end
		end else begin
			if (!ctl_q.stop && (opp != '0)) begin
				ctl_o.stop = 1'b0;
				idx_o      = opp;
				take_opp   = 1'b1;
			end else if (!ctl_q.stop && (same != '0)) begin
				ctl_o.stop = 1'b0;
				idx_o      = same;
			end
		end
	end

	// commit: relink the node where the path broke, or append a fresh node
	assign we      = commit_i && (miss_q || after_q);
	assign widx    = miss_q ? cur_q : (fill_q + 1'b1);
	assign keep    = miss_q ? other_q : '0;
	assign wdata   = bit_i ? {alloc_i, keep} : {keep, alloc_i};
	assign alloc_o = fill_q + 1'b1;
	assign bit_o   = bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q   <= '0;
			fill_q  <= '0;
			miss_q  <= 1'b0;
			after_q <= 1'b0;
		end else begin
			ctl_q <= ctl_i;
			if (ctl_q.valid) begin
				miss_q  <= hit_miss;
				after_q <= (cmd_i == btmx_pkg::CMD_INSERT) && ctl_q.stop;
			end
			if (we && (widx > fill_q)) begin
				fill_q <= widx;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_i;
		if (ctl_q.valid) begin
			cur_q   <= idx_q;
			other_q <= opp;
			bit_q   <= take_opp;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/binary_trie_max_xor_top.sv
// Binary trie max-xor block: a chain of VALUE_BITS level cells plus control.
// Depends on btmx_pkg, btmx_cell and btmx_ram.
// Items are taken one at a time: in_ready is high only in S_IDLE, so a new item waits until the last leaves S_FINISH.
// The walk visits one level cell per cycle.
// The result register lets the next item start while a result waits.
// Reset: empty set, no clearing pass; accepts an item in the first cycle after reset.
`default_nettype none

module binary_trie_max_xor_top #(
	parameter int VALUE_BITS = btmx_pkg::VALUE_BITS_DEF,
	parameter int NODE_COUNT = btmx_pkg::NODE_COUNT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          command,
	input  wire logic [VALUE_BITS-1:0]         value,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [VALUE_BITS-1:0]         max_xor,
	output logic      [btmx_pkg::STATUS_W-1:0] status
);

	localparam int IDX_W = $clog2(NODE_COUNT);
	localparam int CNT_W = $clog2(NODE_COUNT + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FINISH
	} state_t;

	state_t                          state_q;
	logic                            start_q;
	logic                            cmd_q;
	logic [VALUE_BITS-1:0]           value_q;
	logic [btmx_pkg::NEED_W-1:0]     need_q;
	logic [CNT_W-1:0]                next_free_q;
	logic                            nonempty_q;
	logic                            out_valid_q;
	logic [VALUE_BITS-1:0]           max_xor_q;
	logic [btmx_pkg::STATUS_W-1:0]   status_q;

	btmx_pkg::walk_ctl_t ctl [0:VALUE_BITS];
	logic [IDX_W-1:0]    idx [0:VALUE_BITS];
	logic [IDX_W-1:0]    alloc [0:VALUE_BITS];
	logic [VALUE_BITS-1:0] best;

	logic out_free;
	logic fits;
	logic commit;

	assign ctl[0].valid      = start_q;
	assign ctl[0].stop       = 1'b0;
	assign ctl[0].need       = '0;
	assign idx[0]            = IDX_W'(1);      // root
	assign alloc[VALUE_BITS] = IDX_W'(1);      // leaf marker

	for (genvar d = 0; d < VALUE_BITS; d++) begin : g_cell
		localparam int DEPTH = btmx_pkg::cell_depth(d, NODE_COUNT);
		btmx_cell #(
			.IDX_W(IDX_W),
			.DEPTH(DEPTH)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd_i   (cmd_q),
			.bit_i   (value_q[VALUE_BITS-1-d]),
			.ctl_i   (ctl[d]),
			.idx_i   (idx[d]),
			.ctl_o   (ctl[d+1]),
			.idx_o   (idx[d+1]),
			.bit_o   (best[VALUE_BITS-1-d]),
			.commit_i(commit),
			.alloc_i (alloc[d+1]),
			.alloc_o (alloc[d])
		);
	end

	assign out_free = !out_valid_q || out_ready;
	assign fits     = ({1'b0, next_free_q} + (CNT_W+1)'(need_q)) <= (CNT_W+1)'(NODE_COUNT);
	assign commit   = (state_q == S_FINISH) && out_free && (cmd_q == btmx_pkg::CMD_INSERT)
		&& fits;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign max_xor   = max_xor_q;
	assign status    = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= 1'b0;
			cmd_q       <= btmx_pkg::CMD_INSERT;
			value_q     <= '0;
			need_q      <= '0;
			next_free_q <= CNT_W'(1);
			nonempty_q  <= 1'b0;
			out_valid_q <= 1'b0;
			max_xor_q   <= '0;
			status_q    <= btmx_pkg::ST_OK;
		end else begin
			start_q <= (state_q == S_IDLE) && in_valid;
			// a finishing item reloads the result register in the same cycle
			if (out_valid_q && out_ready && (state_q != S_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q   <= command;
						value_q <= value;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (ctl[VALUE_BITS].valid) begin
						need_q  <= ctl[VALUE_BITS].need;
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (cmd_q == btmx_pkg::CMD_INSERT) begin
							max_xor_q <= '0;
							if (fits) begin
								next_free_q <= next_free_q + CNT_W'(need_q);
								nonempty_q  <= 1'b1;
								status_q    <= btmx_pkg::ST_OK;
							end else begin
								status_q <= btmx_pkg::ST_FULL;
							end
						end else if (!nonempty_q) begin
							max_xor_q <= '0;
							status_q  <= btmx_pkg::ST_EMPTY;
						end else begin
							max_xor_q <= best;
							status_q  <= btmx_pkg::ST_OK;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> dv/tb_binary_trie_max_xor_top.sv
// Self-checking testbench for binary_trie_max_xor_top: random and directed inserts/queries.
// Depends on btmx_pkg and the RTL under rtl/core; an in-bench trie predictor
// supplies the expected max_xor/status of every transaction.
`default_nettype none

module tb_binary_trie_max_xor_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VW           = btmx_pkg::VALUE_BITS_DEF;
	localparam int NODES        = btmx_pkg::NODE_COUNT_DEF;
	localparam int SW           = btmx_pkg::STATUS_W;
	localparam int RANDOM_ITEMS = 1530;
	localparam int STALL_AT     = 200;   // results seen before the long receiver hold-off
	localparam int STALL_LEN    = 400;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	logic                command   = btmx_pkg::CMD_INSERT;
	logic [VW-1:0]       value     = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [VW-1:0]       max_xor;
	logic [SW-1:0]       status;

	binary_trie_max_xor_top #(
		.VALUE_BITS(VW),
		.NODE_COUNT(NODES)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.value    (value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.max_xor  (max_xor),
		.status   (status)
	);

	always #4 clk = ~clk;

	typedef struct {
		logic [VW-1:0]       xr;
		logic [SW-1:0]       st;
	} answer_t;

	class trie_scoreboard;
		int            child [NODES][2];   // 0 = no child, root is node 0
		int            free_idx;
		bit            has_values;
		answer_t       answers_due[$];
		int            errors;

		function new();
			for (int n = 0; n < NODES; n++) begin
				child[n][0] = 0;
				child[n][1] = 0;
			end
			free_idx   = 1;
			has_values = 1'b0;
			errors     = 0;
		endfunction

		function logic [SW-1:0] grow_path(logic [VW-1:0] v);
			int cur;
			int lvl;
			int fresh;
			cur = 0;
			lvl = VW - 1;
			while (lvl >= 0 && child[cur][v[lvl]] != 0) begin
				cur = child[cur][v[lvl]];
				lvl--;
			end
			// whole insert is refused if the missing tail does not fit
			if (free_idx + lvl + 1 > NODES) begin
				return btmx_pkg::ST_FULL;
			end
			while (lvl >= 0) begin
				fresh = free_idx;
				free_idx++;
				child[fresh][0] = 0;
				child[fresh][1] = 0;
				child[cur][v[lvl]] = fresh;
				cur = fresh;
				lvl--;
			end
			has_values = 1'b1;
			return btmx_pkg::ST_OK;
		endfunction

		function logic [VW-1:0] best_xor(logic [VW-1:0] v);
			int cur;
			int lvl;
			bit alive;
			logic b;
			logic [VW-1:0] acc;
			cur   = 0;
			alive = 1'b1;
			acc   = '0;
			for (lvl = VW - 1; lvl >= 0 && alive; lvl--) begin
				b = v[lvl];
				if (child[cur][~b] != 0) begin
					acc[lvl] = 1'b1;
					cur = child[cur][~b];
				end else if (child[cur][b] != 0) begin
					cur = child[cur][b];
				end else begin
					alive = 1'b0;
				end
			end
			return acc;
		endfunction

		function void note_item(logic c, logic [VW-1:0] v);
			answer_t a;
			if (c == btmx_pkg::CMD_INSERT) begin
				a.xr = '0;
				a.st = grow_path(v);
			end else if (!has_values) begin
				a.xr = '0;
				a.st = btmx_pkg::ST_EMPTY;
			end else begin
				a.xr = best_xor(v);
				a.st = btmx_pkg::ST_OK;
			end
			answers_due.push_back(a);
		endfunction

		function void check_result(logic [VW-1:0] xr, logic [SW-1:0] st);
			answer_t a;
			if (answers_due.size() == 0) begin
				$error("unexpected result: max_xor %h status %0d", xr, st);
				errors++;
				return;
			end
			a = answers_due.pop_front();
			if (xr !== a.xr) begin
				$error("max_xor mismatch: expected %h, actual %h", a.xr, xr);
				errors++;
			end
			if (st !== a.st) begin
				$error("status mismatch: expected %0d, actual %0d", a.st, st);
				errors++;
			end
		endfunction
	endclass

	trie_scoreboard sb;
	logic [VW-1:0]  tried_vals[$];   // every value offered for insert
	int             sent = 0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 45) return 0;
		if (r < 85) return $urandom_range(3, 1);
		if (r < 97) return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	// drive one transaction, wait for acceptance, then idle for a random gap, sometimes none
	task automatic offer(input logic c, input logic [VW-1:0] v);
		int gap;
		in_valid <= 1'b1;
		command  <= c;
		value    <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_item(c, v);
		if (c == btmx_pkg::CMD_INSERT) tried_vals.push_back(v);
		sent++;
		gap = ((sent / 128) % 4 == 2) ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [VW-1:0] near_known();
		logic [VW-1:0] mask;
		mask = (VW'(1) << $urandom_range(12, 1)) - VW'(1);
		return tried_vals[$urandom_range(tried_vals.size() - 1)] ^ (VW'($urandom) & mask);
	endfunction

	initial begin : feed_side
		int r;
		int sub;
		logic c;
		logic [VW-1:0] v;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty set, duplicates, extremes, alternating patterns
		offer(btmx_pkg::CMD_QUERY,  32'h0000_0000);
		offer(btmx_pkg::CMD_QUERY,  32'hFFFF_FFFF);
		offer(btmx_pkg::CMD_INSERT, 32'h0000_0000);
		offer(btmx_pkg::CMD_INSERT, 32'h0000_0000);
		offer(btmx_pkg::CMD_QUERY,  32'h0000_0000);
		offer(btmx_pkg::CMD_QUERY,  32'hFFFF_FFFF);
		offer(btmx_pkg::CMD_INSERT, 32'hFFFF_FFFF);
		offer(btmx_pkg::CMD_QUERY,  32'h0000_0000);
		offer(btmx_pkg::CMD_QUERY,  32'h8000_0000);
		offer(btmx_pkg::CMD_INSERT, 32'h8000_0000);
		offer(btmx_pkg::CMD_INSERT, 32'h0000_0001);
		offer(btmx_pkg::CMD_QUERY,  32'h7FFF_FFFF);
		offer(btmx_pkg::CMD_QUERY,  32'hAAAA_AAAA);
		offer(btmx_pkg::CMD_QUERY,  32'h5555_5555);
		offer(btmx_pkg::CMD_INSERT, 32'hAAAA_AAAA);
		offer(btmx_pkg::CMD_INSERT, 32'h5555_5555);
		offer(btmx_pkg::CMD_QUERY,  32'h0000_0001);
		offer(btmx_pkg::CMD_QUERY,  32'hFFFF_FFFE);
		offer(btmx_pkg::CMD_INSERT, 32'hFFFF_FFFE);
		offer(btmx_pkg::CMD_INSERT, 32'hFFFF_FFFF);
		offer(btmx_pkg::CMD_QUERY,  32'h1234_5678);
		offer(btmx_pkg::CMD_QUERY,  32'hFFFF_FFFF);

		// random mix: the pool fills part way through, after which only
		// short-tail inserts and duplicates still succeed
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			r   = $urandom_range(99);
			sub = $urandom_range(9);
			if (r < 40) begin
				c = btmx_pkg::CMD_INSERT;
				if (sub < 3) v = $urandom;
				else if (sub < 8) v = near_known();
				else v = tried_vals[$urandom_range(tried_vals.size() - 1)];
			end else begin
				c = btmx_pkg::CMD_QUERY;
				if (sub < 6) v = $urandom;
				else if (sub < 8) v = near_known();
				else if (sub < 9) v = ~tried_vals[$urandom_range(tried_vals.size() - 1)];
				else v = $urandom_range(1) ? '1 : '0;
			end
			offer(c, v);
		end
		in_valid <= 1'b0;

		while (sb.answers_due.size() != 0) @(posedge clk);
		repeat (VW + 8) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin : drain_side
		int hold;
		int seen;
		bit pressed;
		hold    = 0;
		seen    = 0;
		pressed = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				sb.check_result(max_xor, status);
				seen++;
				// one long hold-off so the block backs up into its input
				if (!pressed && seen == STALL_AT) begin
					hold    = STALL_LEN;
					pressed = 1'b1;
				end else if ((seen / 150) % 3 != 1) begin
					hold = pick_gap();
				end
			end
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		#6000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
rtl/core/btmx_pkg.sv
rtl/core/btmx_ram.sv
rtl/core/btmx_cell.sv
rtl/core/binary_trie_max_xor_top.sv
dv/tb_binary_trie_max_xor_top.sv
